/* hdl/bba_pkg.sv */
// Shared types and constants for the buddy block allocator.
// Holds header layout, controller commands and datapath status flags.
// No dependencies.
package bba_pkg;

    localparam int HEAP_BITS      = 16;
    localparam int MIN_BLOCK_LOG2 = 5;
    localparam int HDR_BYTES      = 16;
    localparam int SLOT_W         = HEAP_BITS - MIN_BLOCK_LOG2;
    localparam int SLOTS          = 1 << SLOT_W;
    localparam int ORDERS         = SLOT_W + 1;
    localparam int ORD_W          = $clog2(ORDERS);
    localparam int REQ_W          = 20;
    localparam int NEED_W         = REQ_W + 1;
    localparam int ADDR_W         = 16;
    localparam int BORD_W         = 5;
    localparam int USED_W         = 17;
    localparam int STAT_W         = 2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              is_free;
        logic [ORD_W-1:0]  order;
        logic [SLOT_W-1:0] next;
        logic              next_valid;
    } hdr_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_ERR,
        OP_ALLOC_READ,
        OP_POP,
        OP_SPLIT,
        OP_ALLOC_FIN,
        OP_FREE_READ,
        OP_FREE_TAKE,
        OP_BUD_READ,
        OP_WALK_START,
        OP_WALK_READ,
        OP_WALK_STEP,
        OP_UNLINK,
        OP_ABSORB,
        OP_PUSH_FIN
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STAT_W-1:0] err;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free_op;
        logic req_zero;
        logic too_big;
        logic found;
        logic fa_bad;
        logic ord_gt_want;
        logic hdr_taken;
        logic bud_ok;
        logic top_ord;
        logic cur_ok;
        logic cur_hit;
    } stat_t;

endpackage

/* hdl/buddy_block_allocator.sv */
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
// Usage: a transaction is accepted at a rising edge with start high and
// busy low; action selects allocate (request_bytes) or free (free_address).
// Each transaction yields exactly one result, shown for one cycle while done
// is high: status, payload_address, block_order and used_bytes. The receiver
// cannot stall; it must take the result in that cycle.
// Allocate reads the smallest fitting free list, pops its head block and
// splits it down to the wanted order; free checks the header, then merges
// with each free buddy of equal order, walking the buddy's free list to
// unlink it, and pushes the result onto its list.
// The header memory has a registered read port and a write port, and
// the free lists are linked through it; busy stays high while a transaction
// is in flight, so one transaction is worked on at a time.
// Reset: after rst_n is released a clearing pass writes all 2048 header
// entries, one per cycle, leaving one free block spanning the heap; busy is
// high during the pass and no transaction is accepted.
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [REQ_W-1:0]   request_bytes,
    input  logic [ADDR_W-1:0]  free_address,
    output logic               done,
    output logic [STAT_W-1:0]  status,
    output logic [ADDR_W-1:0]  payload_address,
    output logic [BORD_W-1:0]  block_order,
    output logic [USED_W-1:0]  used_bytes
);

    cmd_t  cmd;
    stat_t st;

    bba_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    bba_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .action          (action),
        .request_bytes   (request_bytes),
        .free_address    (free_address),
        .st              (st),
        .status          (status),
        .payload_address (payload_address),
        .block_order     (block_order),
        .used_bytes      (used_bytes),
        .done            (done)
    );

endmodule

/* hdl/bba_datapath.sv */
// Datapath of the buddy block allocator: header memory, free-list heads,
// working registers and result registers. Driven by bba_ctrl commands.
// Depends on bba_pkg.
module bba_datapath
    import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic                action,
    input  logic [REQ_W-1:0]    request_bytes,
    input  logic [ADDR_W-1:0]   free_address,
    output stat_t               st,
    output logic [STAT_W-1:0]   status,
    output logic [ADDR_W-1:0]   payload_address,
    output logic [BORD_W-1:0]   block_order,
    output logic [USED_W-1:0]   used_bytes,
    output logic                done
);

    hdr_t              mem [SLOTS];
    hdr_t              rdata_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    hdr_t              wr_data;

    logic [SLOT_W-1:0] head_reg [ORDERS];
    logic              head_valid_reg [ORDERS];

    logic [SLOT_W-1:0] clr_reg;
    logic [USED_W-1:0] bytes_reg;
    logic              done_reg;

    logic              act_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [ADDR_W-1:0] fa_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] bslot_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic              cur_ok_reg;
    logic [SLOT_W-1:0] prev_reg;
    logic              have_prev_reg;
    hdr_t              prev_data_reg;
    hdr_t              bdata_reg;
    logic [ORD_W-1:0]  ord_reg;
    logic [ORD_W-1:0]  want_reg;
    logic [STAT_W-1:0] status_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [BORD_W-1:0] bord_reg;

    logic [NEED_W-1:0] need;
    logic [HEAP_BITS-1:0] need_m1;
    logic [BORD_W-1:0] bit_len;
    logic [ORD_W-1:0]  want_idx;
    logic              found;
    logic [ORD_W-1:0]  found_idx;
    logic [ADDR_W-1:0] fa_off;
    logic [SLOT_W-1:0] fa_slot;
    logic [ORD_W-1:0]  ord_dn;
    logic [SLOT_W-1:0] split_slot;
    logic [SLOT_W-1:0] bud_slot;
    logic [SLOT_W-1:0] hi_slot;
    logic [SLOT_W-1:0] lo_slot;
    logic [USED_W-1:0] want_size;
    logic [USED_W-1:0] take_size;
    logic [HEAP_BITS-1:0] alloc_off;

    // Request sizing: the block's log2 size is the bit length of (need - 1), at least MIN_BLOCK_LOG2.
    always_comb
    begin
        need    = NEED_W'(req_reg) + NEED_W'(HDR_BYTES);
        need_m1 = HEAP_BITS'(need - NEED_W'(1));
        bit_len = '0;
        for (int i = 0; i < HEAP_BITS; i++)
        begin
            if (need_m1[i])
            begin
                bit_len = BORD_W'(i + 1);
            end
        end
        if (bit_len < BORD_W'(MIN_BLOCK_LOG2))
        begin
            want_idx = '0;
        end
        else
        begin
            want_idx = ORD_W'(bit_len - BORD_W'(MIN_BLOCK_LOG2));
        end
    end

    // Smallest non-empty list at or above the wanted order.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = ORDERS - 1; i >= 0; i--)
        begin
            if (head_valid_reg[i] && (ORD_W'(i) >= want_idx))
            begin
                found     = 1'b1;
                found_idx = ORD_W'(i);
            end
        end
    end

    always_comb
    begin
        fa_off     = fa_reg - ADDR_W'(HDR_BYTES);
        fa_slot    = fa_off[MIN_BLOCK_LOG2 +: SLOT_W];
        ord_dn     = ord_reg - ORD_W'(1);
        split_slot = slot_reg + SLOT_W'((SLOT_W + 1)'(1) << ord_dn);
        bud_slot   = slot_reg ^ SLOT_W'((SLOT_W + 1)'(1) << ord_reg);
        hi_slot    = (slot_reg > bslot_reg) ? slot_reg : bslot_reg;
        lo_slot    = (slot_reg > bslot_reg) ? bslot_reg : slot_reg;
        want_size  = USED_W'(1) << (USED_W'(want_reg) + USED_W'(MIN_BLOCK_LOG2));
        take_size  = USED_W'(1) << (USED_W'(rdata_reg.order) + USED_W'(MIN_BLOCK_LOG2));
        alloc_off  = {slot_reg, {MIN_BLOCK_LOG2{1'b0}}};
    end

    always_comb
    begin
        st.clr_last    = (clr_reg == {SLOT_W{1'b1}});
        st.is_free_op  = (act_reg == ACT_FREE);
        st.req_zero    = (req_reg == '0);
        st.too_big     = (need > NEED_W'(1 << HEAP_BITS));
        st.found       = found;
        st.fa_bad      = (fa_reg < ADDR_W'(HDR_BYTES))
                         || (fa_off[MIN_BLOCK_LOG2-1:0] != '0);
        st.ord_gt_want = (ord_reg > want_reg);
        st.hdr_taken   = rdata_reg.valid && !rdata_reg.is_free;
        st.bud_ok      = rdata_reg.valid && rdata_reg.is_free
                         && (rdata_reg.order == ord_reg);
        st.top_ord     = (ord_reg == ORD_W'(ORDERS - 1));
        st.cur_ok      = cur_ok_reg;
        st.cur_hit     = (cur_reg == bslot_reg);
    end

    // Memory port selection.
    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        case (cmd.op)
            OP_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == '0)
                begin
                    wr_data = '{valid: 1'b1, is_free: 1'b1, order: ORD_W'(ORDERS - 1),
                                next: '0, next_valid: 1'b0};
                end
            end
            OP_ALLOC_READ: rd_addr = head_reg[found_idx];
            OP_FREE_READ:  rd_addr = fa_slot;
            OP_BUD_READ:   rd_addr = bud_slot;
            OP_WALK_READ:  rd_addr = cur_reg;
            OP_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_addr = split_slot;
                wr_data = '{valid: 1'b1, is_free: 1'b1, order: ord_dn,
                            next: head_reg[ord_dn], next_valid: head_valid_reg[ord_dn]};
            end
            OP_ALLOC_FIN:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_reg;
                wr_data = '{valid: 1'b1, is_free: 1'b0, order: want_reg,
                            next: '0, next_valid: 1'b0};
            end
            OP_UNLINK:
            begin
                wr_en              = have_prev_reg;
                wr_addr            = prev_reg;
                wr_data            = prev_data_reg;
                wr_data.next       = bdata_reg.next;
                wr_data.next_valid = bdata_reg.next_valid;
            end
            OP_ABSORB:
            begin
                // The upper half of a merged pair no longer starts a block.
                wr_en   = 1'b1;
                wr_addr = hi_slot;
            end
            OP_PUSH_FIN:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_reg;
                wr_data = '{valid: 1'b1, is_free: 1'b1, order: ord_reg,
                            next: head_reg[ord_reg], next_valid: head_valid_reg[ord_reg]};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Control state: clearing counter, list heads, byte count, result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            bytes_reg <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < ORDERS; i++)
            begin
                head_reg[i]       <= '0;
                head_valid_reg[i] <= (i == ORDERS - 1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (cmd.op)
                OP_CLEAR:
                begin
                    clr_reg <= clr_reg + SLOT_W'(1);
                end
                OP_ERR:
                begin
                    done_reg <= 1'b1;
                end
                OP_POP:
                begin
                    head_reg[ord_reg]       <= rdata_reg.next;
                    head_valid_reg[ord_reg] <= rdata_reg.next_valid;
                end
                OP_SPLIT:
                begin
                    head_reg[ord_dn]       <= split_slot;
                    head_valid_reg[ord_dn] <= 1'b1;
                end
                OP_ALLOC_FIN:
                begin
                    bytes_reg <= bytes_reg + want_size;
                    done_reg  <= 1'b1;
                end
                OP_FREE_TAKE:
                begin
                    bytes_reg <= (bytes_reg >= take_size) ? (bytes_reg - take_size) : '0;
                end
                OP_UNLINK:
                begin
                    if (!have_prev_reg)
                    begin
                        head_reg[ord_reg]       <= bdata_reg.next;
                        head_valid_reg[ord_reg] <= bdata_reg.next_valid;
                    end
                end
                OP_PUSH_FIN:
                begin
                    head_reg[ord_reg]       <= slot_reg;
                    head_valid_reg[ord_reg] <= 1'b1;
                    done_reg                <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                act_reg <= action;
                req_reg <= request_bytes;
                fa_reg  <= free_address;
            end
            OP_ERR:
            begin
                status_reg <= cmd.err;
                addr_reg   <= '0;
                bord_reg   <= '0;
            end
            OP_ALLOC_READ:
            begin
                slot_reg <= head_reg[found_idx];
                ord_reg  <= found_idx;
                want_reg <= want_idx;
            end
            OP_SPLIT:
            begin
                ord_reg <= ord_dn;
            end
            OP_ALLOC_FIN:
            begin
                status_reg <= ST_OK;
                addr_reg   <= ADDR_W'(alloc_off + HEAP_BITS'(HDR_BYTES));
                bord_reg   <= BORD_W'(want_reg) + BORD_W'(MIN_BLOCK_LOG2);
            end
            OP_FREE_READ:
            begin
                slot_reg <= fa_slot;
            end
            OP_FREE_TAKE:
            begin
                ord_reg <= rdata_reg.order;
            end
            OP_BUD_READ:
            begin
                bslot_reg <= bud_slot;
            end
            OP_WALK_START:
            begin
                bdata_reg     <= rdata_reg;
                cur_reg       <= head_reg[ord_reg];
                cur_ok_reg    <= head_valid_reg[ord_reg];
                have_prev_reg <= 1'b0;
            end
            OP_WALK_STEP:
            begin
                prev_reg      <= cur_reg;
                prev_data_reg <= rdata_reg;
                have_prev_reg <= 1'b1;
                cur_reg       <= rdata_reg.next;
                cur_ok_reg    <= rdata_reg.next_valid;
            end
            OP_ABSORB:
            begin
                slot_reg <= lo_slot;
                ord_reg  <= ord_reg + ORD_W'(1);
            end
            OP_PUSH_FIN:
            begin
                status_reg <= ST_OK;
                addr_reg   <= '0;
                bord_reg   <= BORD_W'(ord_reg) + BORD_W'(MIN_BLOCK_LOG2);
            end
            default:
            begin
            end
        endcase
    end

    assign status          = status_reg;
    assign payload_address = addr_reg;
    assign block_order     = bord_reg;
    assign used_bytes      = bytes_reg;
    assign done            = done_reg;

endmodule

/* hdl/bba_ctrl.sv */
// Controller state machine of the buddy block allocator.
// Sequences the clearing pass, allocation, split, free, merge and list walk steps.
// Depends on bba_pkg.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t st,
    output cmd_t  cmd,
    output logic  busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ALLOC_POP,
        S_SPLIT,
        S_FREE_CHK,
        S_MERGE,
        S_BUD_CHK,
        S_WALK,
        S_WALK_NEXT,
        S_ABSORB
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.err    = ST_OK;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (st.is_free_op)
                begin
                    if (st.fa_bad)
                    begin
                        cmd.op  = OP_ERR;
                        cmd.err = ST_BAD_FREE;
                    end
                    else
                    begin
                        cmd.op     = OP_FREE_READ;
                        state_next = S_FREE_CHK;
                    end
                end
                else if (st.req_zero)
                begin
                    cmd.op  = OP_ERR;
                    cmd.err = ST_ZERO;
                end
                else if (st.too_big || !st.found)
                begin
                    cmd.op  = OP_ERR;
                    cmd.err = ST_NO_SPACE;
                end
                else
                begin
                    cmd.op     = OP_ALLOC_READ;
                    state_next = S_ALLOC_POP;
                end
            end
            S_ALLOC_POP:
            begin
                cmd.op     = OP_POP;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (st.ord_gt_want)
                begin
                    cmd.op = OP_SPLIT;
                end
                else
                begin
                    cmd.op     = OP_ALLOC_FIN;
                    state_next = S_IDLE;
                end
            end
            S_FREE_CHK:
            begin
                if (st.hdr_taken)
                begin
                    cmd.op     = OP_FREE_TAKE;
                    state_next = S_MERGE;
                end
                else
                begin
                    cmd.op     = OP_ERR;
                    cmd.err    = ST_BAD_FREE;
                    state_next = S_IDLE;
                end
            end
            S_MERGE:
            begin
                if (st.top_ord)
                begin
                    cmd.op     = OP_PUSH_FIN;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_BUD_READ;
                    state_next = S_BUD_CHK;
                end
            end
            S_BUD_CHK:
            begin
                if (st.bud_ok)
                begin
                    cmd.op     = OP_WALK_START;
                    state_next = S_WALK;
                end
                else
                begin
                    cmd.op     = OP_PUSH_FIN;
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                // The buddy is looked up in its list so its link can be cut.
                if (!st.cur_ok)
                begin
                    cmd.op     = OP_PUSH_FIN;
                    state_next = S_IDLE;
                end
                else if (st.cur_hit)
                begin
                    cmd.op     = OP_UNLINK;
                    state_next = S_ABSORB;
                end
                else
                begin
                    cmd.op     = OP_WALK_READ;
                    state_next = S_WALK_NEXT;
                end
            end
            S_WALK_NEXT:
            begin
                cmd.op     = OP_WALK_STEP;
                state_next = S_WALK;
            end
            S_ABSORB:
            begin
                cmd.op     = OP_ABSORB;
                state_next = S_MERGE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule
